### sv/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`endif

### sv/fra_pkg.sv
// Shared constants and the walk token type for the residency accumulator.
`timescale 1ns / 1ps

package fra_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int TIME_W            = 64;
    localparam int FREQ_W            = 32;
    localparam int SLOT_W            = 4;

    typedef struct packed {
        logic              valid;
        logic [FREQ_W-1:0] charge;
        logic [TIME_W-1:0] span;
        logic              done;
        logic              added;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] slot_time;
    } t_token;

endpackage

### sv/fra_cell.sv
// One table entry: matches the passing token, accumulates or inserts, forwards it.
`timescale 1ns / 1ps

module fra_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_count,
    input  fra_pkg::t_token  i_tok,
    output fra_pkg::t_token  o_tok
);
    import fra_pkg::*;

    logic [FREQ_W-1:0] r_freq;
    logic [TIME_W-1:0] r_time;
    t_token            r_tok;
    t_token            n_tok;
    logic              w_match;
    logic              w_ins;
    logic [TIME_W-1:0] w_sum;

    always_comb begin
        w_sum   = r_time + i_tok.span;
        w_match = i_tok.valid && !i_tok.done && (CNT_W'(IDX) < i_count)
                  && (r_freq == i_tok.charge);
        w_ins   = i_tok.valid && !i_tok.done && (CNT_W'(IDX) == i_count);
        n_tok   = i_tok;
        if (w_match) begin
            n_tok.done      = 1'b1;
            n_tok.slot      = SLOT_W'(IDX);
            n_tok.slot_time = w_sum;
        end else if (w_ins) begin
            n_tok.done      = 1'b1;
            n_tok.added     = 1'b1;
            n_tok.slot      = SLOT_W'(IDX);
            n_tok.slot_time = i_tok.span;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_match) begin
            r_time <= w_sum;
        end else if (w_ins) begin
            r_freq <= i_tok.charge;
            r_time <= i_tok.span;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

### sv/frequency_residency_accumulator_unit.sv
// Top level: frequency residency accumulator built as a chain of table cells.
//
// Input channel (i_in_valid / o_in_stall) takes one frequency-change event per
// transfer: timestamp, new frequency and the idle flag of the ending interval.
// Output channel (o_out_valid / i_out_stall) returns exactly one result per event:
// slot, charged frequency, slot time, running total and the new/full flags.
// The elapsed time is charged to the previous frequency, or to 0 when idle.
// From input transfer to output valid, the interval is formed at the transfer and
// registered as a lookup token, passes through one register per table cell as it
// walks the chain, and is folded into the running total in the output register.
// One event is in flight at a time; o_in_stall stays high until its result is
// transferred, so a new event is not taken before the last one is through.
// A receiver stall holds the result and its fields stable and keeps the input
// stalled. Reset clears the last timestamp, current frequency, entry count and
// total; table contents need no clearing since only used entries are matched.
`timescale 1ns / 1ps

module frequency_residency_accumulator_unit #(
    parameter int TABLE_ENTRIES = fra_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [fra_pkg::TIME_W-1:0] i_event_time,
    input  logic [fra_pkg::FREQ_W-1:0] i_new_freq,
    input  logic                       i_was_idle,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [fra_pkg::SLOT_W-1:0] o_slot,
    output logic [fra_pkg::FREQ_W-1:0] o_charged_freq,
    output logic [fra_pkg::TIME_W-1:0] o_slot_time,
    output logic [fra_pkg::TIME_W-1:0] o_total_time,
    output logic                       o_new_entry,
    output logic                       o_table_full
);
    import fra_pkg::*;

    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    logic              r_busy;
    logic [TIME_W-1:0] r_last_time;
    logic [FREQ_W-1:0] r_cur_freq;
    logic [CNT_W-1:0]  r_count;
    logic [TIME_W-1:0] r_sum;
    t_token            r_inj;
    t_token            n_inj;
    logic [TIME_W-1:0] n_sum;
    logic              r_out_valid;
    logic [SLOT_W-1:0] r_slot;
    logic [FREQ_W-1:0] r_charged_freq;
    logic [TIME_W-1:0] r_slot_time;
    logic [TIME_W-1:0] r_total_time;
    logic              r_new_entry;
    logic              r_table_full;
    logic              w_accept;
    t_token            w_exit;

    t_token                 w_tok [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES:0] w_vld;

    assign o_in_stall = r_busy;
    assign w_accept   = i_in_valid && !r_busy;
    assign w_tok[0]   = r_inj;
    assign w_exit     = w_tok[TABLE_ENTRIES];

    always_comb begin
        n_inj           = '0;
        n_inj.valid     = w_accept;
        n_inj.charge    = i_was_idle ? '0 : r_cur_freq;
        n_inj.span      = (r_last_time != '0) ? (i_event_time - r_last_time)
                                              : TIME_W'(1);
        n_sum           = w_exit.done ? (r_sum + w_exit.span) : r_sum;
        for (int k = 0; k <= TABLE_ENTRIES; k++) begin
            w_vld[k] = w_tok[k].valid;
        end
    end

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        fra_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_count (r_count),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_last_time <= '0;
            r_cur_freq  <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_inj.valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_inj <= n_inj;
            if (w_accept) begin
                r_busy      <= 1'b1;
                r_last_time <= i_event_time;
                r_cur_freq  <= i_new_freq;
            end
            if (w_exit.valid) begin
                r_out_valid    <= 1'b1;
                r_sum          <= n_sum;
                r_slot         <= w_exit.done ? w_exit.slot : '0;
                r_charged_freq <= w_exit.charge;
                r_slot_time    <= w_exit.done ? w_exit.slot_time : '0;
                r_total_time   <= n_sum;
                r_new_entry    <= w_exit.added;
                r_table_full   <= !w_exit.done;
                if (w_exit.added) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
                r_busy      <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_slot         = r_slot;
    assign o_charged_freq = r_charged_freq;
    assign o_slot_time    = r_slot_time;
    assign o_total_time   = r_total_time;
    assign o_new_entry    = r_new_entry;
    assign o_table_full   = r_table_full;

    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > CNT_W'(TABLE_ENTRIES))
    `ASSERT_CLK(a_one_in_flight, i_clk, i_rst_n, $onehot0({w_vld, r_out_valid}))
    `ASSERT_CLK(a_idle_empty, i_clk, i_rst_n, !r_busy |-> (w_vld == '0 && !r_out_valid))
    `ASSERT_CLK(a_out_from_chain, i_clk, i_rst_n,
                $rose(r_out_valid) |-> $past(w_vld[TABLE_ENTRIES]))

endmodule

### test/frequency_residency_accumulator_unit_test.sv
// Self-checking testbench for the frequency residency accumulator unit.
`timescale 1ns / 1ps

module frequency_residency_accumulator_unit_test;

    import fra_pkg::*;

    localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_EVENTS = 480;
    localparam int CALM_EVENTS   = 100;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic [FREQ_W-1:0] charged_freq;
        logic [TIME_W-1:0] slot_time;
        logic [TIME_W-1:0] total_time;
        logic              new_entry;
        logic              table_full;
    } t_residency_result;

    class residency_scoreboard;
        logic [TIME_W-1:0] prior_stamp;
        logic [FREQ_W-1:0] running_freq;
        logic [FREQ_W-1:0] slot_freq [TABLE_ENTRIES];
        logic [TIME_W-1:0] slot_acc [TABLE_ENTRIES];
        int                used_slots;
        logic [TIME_W-1:0] grand_total;
        t_residency_result expected_q [$];
        int                errors;

        function new();
            prior_stamp  = '0;
            running_freq = '0;
            used_slots   = 0;
            grand_total  = '0;
            errors       = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_event(logic [TIME_W-1:0] stamp, logic [FREQ_W-1:0] freq,
                                 logic idle);
            logic [TIME_W-1:0] span;
            logic [FREQ_W-1:0] charge;
            t_residency_result r;
            int                hit;
            span   = (prior_stamp != '0) ? stamp - prior_stamp : TIME_W'(1);
            charge = idle ? '0 : running_freq;
            hit    = -1;
            for (int k = 0; k < used_slots; k++) begin
                if (hit < 0 && slot_freq[k] == charge)
                    hit = k;
            end
            r = '{default: '0};
            r.charged_freq = charge;
            if (hit < 0 && used_slots < TABLE_ENTRIES) begin
                hit            = used_slots;
                slot_freq[hit] = charge;
                slot_acc[hit]  = '0;
                used_slots++;
                r.new_entry    = 1'b1;
            end
            if (hit < 0) begin
                r.table_full = 1'b1;
            end else begin
                slot_acc[hit] += span;
                grand_total   += span;
                r.slot         = SLOT_W'(hit);
                r.slot_time    = slot_acc[hit];
            end
            r.total_time = grand_total;
            running_freq = freq;
            prior_stamp  = stamp;
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void compare_field(string name, logic [TIME_W-1:0] exp_val,
                                    logic [TIME_W-1:0] act_val);
            if (exp_val !== act_val) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(t_residency_result got);
            t_residency_result want;
            if (expected_q.size() == 0) begin
                $error("result with no event pending: slot=%0d freq=0x%0h",
                       got.slot, got.charged_freq);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("slot", TIME_W'(want.slot), TIME_W'(got.slot));
            compare_field("charged_freq", TIME_W'(want.charged_freq),
                          TIME_W'(got.charged_freq));
            compare_field("slot_time", want.slot_time, got.slot_time);
            compare_field("total_time", want.total_time, got.total_time);
            compare_field("new_entry", TIME_W'(want.new_entry), TIME_W'(got.new_entry));
            compare_field("table_full", TIME_W'(want.table_full),
                          TIME_W'(got.table_full));
        endfunction
    endclass

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_stall;
    logic [TIME_W-1:0] i_event_time = '0;
    logic [FREQ_W-1:0] i_new_freq   = '0;
    logic              i_was_idle   = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall  = 1'b0;
    logic [SLOT_W-1:0] o_slot;
    logic [FREQ_W-1:0] o_charged_freq;
    logic [TIME_W-1:0] o_slot_time;
    logic [TIME_W-1:0] o_total_time;
    logic              o_new_entry;
    logic              o_table_full;

    residency_scoreboard sb = new();
    bit                  gaps_on = 1'b1;
    int                  stall_left = 0;
    int                  quiet_cycles = 0;
    logic [TIME_W-1:0]   prev_stamp = '0;
    logic [FREQ_W-1:0]   known_freq [16];

    frequency_residency_accumulator_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_event_time(i_event_time),
        .i_new_freq(i_new_freq),
        .i_was_idle(i_was_idle),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_slot(o_slot),
        .o_charged_freq(o_charged_freq),
        .o_slot_time(o_slot_time),
        .o_total_time(o_total_time),
        .o_new_entry(o_new_entry),
        .o_table_full(o_table_full)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            stall_left  <= $urandom_range(0, 5);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_residency_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.slot         = o_slot;
            got.charged_freq = o_charged_freq;
            got.slot_time    = o_slot_time;
            got.total_time   = o_total_time;
            got.new_entry    = o_new_entry;
            got.table_full   = o_table_full;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("frequency_residency_accumulator_unit_test: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Call at a falling edge; returns at the falling edge after the transfer.
    task automatic send_event(logic [TIME_W-1:0] stamp, logic [FREQ_W-1:0] freq,
                              logic idle);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_event_time <= stamp;
        i_new_freq   <= freq;
        i_was_idle   <= idle;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_event(stamp, freq, idle);
        prev_stamp = stamp;
        @(negedge i_clk);
    endtask

    // Hold the sender until every expected result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do
            @(negedge i_clk);
        while (sb.pending() != 0);
    endtask

    task automatic send_random_event();
        logic [TIME_W-1:0] stamp;
        logic [FREQ_W-1:0] freq;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            stamp = prev_stamp + TIME_W'($urandom_range(1, 5000));
        else if (pick < 88)
            stamp = {$urandom, $urandom};
        else if (pick < 93)
            stamp = '0;
        else if (pick < 97)
            stamp = prev_stamp - TIME_W'($urandom_range(1, 1000));
        else
            stamp = prev_stamp;
        if ($urandom_range(0, 4) != 0)
            freq = known_freq[4'($urandom_range(0, 15))];
        else
            freq = $urandom;
        send_event(stamp, freq, $urandom_range(0, 3) == 0);
    endtask

    initial begin
        known_freq[0] = 32'h0001_0000;
        known_freq[1] = 32'h0002_0000;
        known_freq[2] = 32'hFFFF_FFFF;
        for (int k = 0; k < 13; k++)
            known_freq[k + 3] = 32'h1000_0000 + FREQ_W'(k) * 32'h0101_1011;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // first event, zero timestamp, all-ones timestamp, time running backwards
        send_event('0, known_freq[0], 1'b0);
        send_event('0, known_freq[1], 1'b0);
        send_event('1, known_freq[2], 1'b0);
        send_event(64'd5, '0, 1'b0);
        send_event(64'd100, known_freq[0], 1'b1);
        send_event(64'd200, known_freq[3], 1'b0);
        // fill the table, then miss on a full table
        for (int k = 1; k < 13; k++)
            send_event(64'd300 + 64'd1000 * TIME_W'(k), known_freq[k + 3], 1'b0);
        send_event(64'd20000, 32'h8000_0001, 1'b0);
        send_event(64'd21000, known_freq[0], 1'b0);
        send_event(64'd22000, known_freq[1], 1'b0);
        drain_results();

        for (int n = 0; n < RANDOM_EVENTS; n++) begin
            if (n == RANDOM_EVENTS / 2)
                drain_results();
            if (n == RANDOM_EVENTS - CALM_EVENTS)
                gaps_on = 1'b0;
            send_random_event();
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (TABLE_ENTRIES + 4) @(posedge i_clk);
        if (sb.errors == 0)
            $display("frequency_residency_accumulator_unit_test: clean");
        else
            $display("frequency_residency_accumulator_unit_test: errors");
        $finish;
    end

endmodule
